// ===== rtl/sac_pkg.sv =====
// Shared types, codes and defaults of the set-associative cache LRU tracker.
package sac_pkg;

	localparam int SAC_MAX_SET_BITS = 10;
	localparam int SAC_MAX_WAYS     = 8;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 6;

	localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_BITS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_WAYS        = 2'd2;

	localparam logic [1:0] OPC_MODIFY = 2'd2;

	localparam logic [1:0] OUT_HIT   = 2'd0;
	localparam logic [1:0] OUT_FILL  = 2'd1;
	localparam logic [1:0] OUT_EVICT = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] access_address;
	} sac_req_t;

	typedef struct packed {
		logic [1:0]  outcome;
		logic [2:0]  way_used;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] eviction_total;
	} sac_res_t;

	typedef struct packed {
		logic clear_step;
		logic capture;
		logic decide;
		logic commit;
	} sac_cmd_t;

	typedef struct packed {
		logic clear_last;
	} sac_stat_t;

endpackage

// ===== rtl/sac_stream_if.sv =====
// Valid/ready stream channel carrying one request or result payload.
interface sac_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/set_assoc_cache_lru_tracker.sv =====
// Top level of the set-associative cache LRU tracker.
// Each request (opcode, address) is looked up in a set of up to MAX_WAYS ways
// and answered by one result: hit, fill of a free way or eviction of the least
// recently stamped way, with the way used and saturating hit, miss and
// eviction totals. A request passes through capture, lookup and commit steps: the
// set row is read from a single-port row memory on acceptance, the ways are compared
// and the LRU way chosen in the next cycle, and the row is written back with the
// result in the commit step; the next request is taken the cycle after. The result sits in an
// output register, so a new request is accepted while it waits; a request
// finishing while the previous result is still held waits in the commit step.
// After reset the block clears the valid bits of every set, one row per cycle,
// and takes no request until that is done.
// Configuration writes are taken at any time but must only be issued while
// the block is idle; lines are never cleared by them.
module set_assoc_cache_lru_tracker #(
	parameter int MAX_SET_BITS = sac_pkg::SAC_MAX_SET_BITS,
	parameter int MAX_WAYS     = sac_pkg::SAC_MAX_WAYS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sac_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sac_pkg::CFG_DATA_W-1:0]  cfg_data,
	sac_stream_if.sink                      req,
	sac_stream_if.source                    res
);
	import sac_pkg::*;

	sac_cmd_t  cmd;
	sac_stat_t stat;

	sac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sac_datapath #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_payload (req.payload),
		.res_payload (res.payload)
	);

endmodule

// ===== rtl/sac_datapath.sv =====
// Datapath: configuration, set memory, tag compare, LRU select and totals.
module sac_datapath #(
	parameter int MAX_SET_BITS = sac_pkg::SAC_MAX_SET_BITS,
	parameter int MAX_WAYS     = sac_pkg::SAC_MAX_WAYS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sac_pkg::sac_cmd_t                  cmd,
	output sac_pkg::sac_stat_t                 stat,
	input  logic                               cfg_we,
	input  logic [sac_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [sac_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  sac_pkg::sac_req_t                  req_payload,
	output sac_pkg::sac_res_t                  res_payload
);
	import sac_pkg::*;

	localparam int SETS   = 1 << MAX_SET_BITS;
	localparam int SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CNT_W  = $clog2(MAX_WAYS + 1) + 1;
	localparam int LEAVES = 1 << WAY_W;

	typedef struct packed {
		logic        valid;
		logic [63:0] tag;
		logic [31:0] stamp;
	} line_t;

	typedef line_t [MAX_WAYS-1:0] row_t;

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [1:0] b);
		logic [32:0] s;
		s = {1'b0, a} + 33'(b);
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	logic [3:0] set_bits_q;
	logic [5:0] offset_bits_q;
	logic [3:0] ways_q;

	logic [4:0]       sb_eff;
	logic [6:0]       split_total;
	logic [63:0]      addr_shifted;
	logic [63:0]      set_mask;
	logic [63:0]      set_full;
	logic [SET_AW-1:0] set_in;
	logic [63:0]      tag_in;
	logic [CNT_W-1:0] ways_eff;

	row_t             row_mem [SETS];
	row_t             rd_row_q;
	logic [SET_AW-1:0] clr_q;
	logic [SET_AW-1:0] set_q;
	logic [63:0]      tag_q;
	logic             mod_q;

	logic             hit_c;
	logic             free_c;
	logic [WAY_W-1:0] hit_way_c;
	logic [WAY_W-1:0] free_way_c;
	logic             lvl_en    [WAY_W+1][LEAVES];
	logic [31:0]      lvl_stamp [WAY_W+1][LEAVES];
	logic [WAY_W-1:0] lvl_idx   [WAY_W+1][LEAVES];

	logic             hit_q;
	logic             free_q;
	logic [WAY_W-1:0] way_q;

	logic [31:0] clock_q;
	logic [31:0] hit_cnt_q;
	logic [31:0] miss_cnt_q;
	logic [31:0] evict_cnt_q;
	logic [31:0] stamp_new;
	logic [31:0] hit_cnt_nx;
	logic [31:0] miss_cnt_nx;
	logic [31:0] evict_cnt_nx;
	logic [1:0]  hit_add;
	row_t        new_row;
	sac_res_t    res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= 4'd0;
			offset_bits_q <= 6'd0;
			ways_q        <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SET_BITS:    set_bits_q    <= cfg_data[3:0];
				CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
				CFG_WAYS:        ways_q        <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sb_eff = ({1'b0, set_bits_q} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
			: {1'b0, set_bits_q};
		split_total  = 7'(sb_eff) + 7'(offset_bits_q);
		addr_shifted = req_payload.access_address >> offset_bits_q;
		set_mask     = (64'd1 << sb_eff) - 64'd1;
		set_full     = addr_shifted & set_mask;
		set_in       = set_full[SET_AW-1:0];
		tag_in       = (split_total >= 7'd64) ? 64'd0
			: (req_payload.access_address >> split_total);
		if (ways_q == 4'd0) begin
			ways_eff = CNT_W'(1);
		end else if (CNT_W'(ways_q) > CNT_W'(MAX_WAYS)) begin
			ways_eff = CNT_W'(MAX_WAYS);
		end else begin
			ways_eff = CNT_W'(ways_q);
		end
	end

	assign stat.clear_last = (clr_q == SET_AW'(SETS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + SET_AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			row_mem[clr_q] <= '0;
		end else if (cmd.commit) begin
			row_mem[set_q] <= new_row;
		end
		if (cmd.capture) begin
			rd_row_q <= row_mem[set_in];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			set_q <= set_in;
			tag_q <= tag_in;
			mod_q <= (req_payload.opcode == OPC_MODIFY);
		end
	end

	always_comb begin
		hit_c      = 1'b0;
		free_c     = 1'b0;
		hit_way_c  = '0;
		free_way_c = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (CNT_W'(w) < ways_eff) begin
				if (rd_row_q[w].valid && rd_row_q[w].tag == tag_q) begin
					hit_c     = 1'b1;
					hit_way_c = WAY_W'(w);
				end
				if (!rd_row_q[w].valid) begin
					free_c     = 1'b1;
					free_way_c = WAY_W'(w);
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l <= WAY_W; l++) begin
			for (int i = 0; i < LEAVES; i++) begin
				lvl_en[l][i]    = 1'b0;
				lvl_stamp[l][i] = '0;
				lvl_idx[l][i]   = '0;
			end
		end
		for (int i = 0; i < LEAVES; i++) begin
			if (i < MAX_WAYS) begin
				lvl_en[0][i]    = (CNT_W'(i) < ways_eff);
				lvl_stamp[0][i] = rd_row_q[i].stamp;
			end
			lvl_idx[0][i] = WAY_W'(i);
		end
		for (int l = 0; l < WAY_W; l++) begin
			for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
				if (lvl_en[l][2*i+1] && (!lvl_en[l][2*i]
					|| lvl_stamp[l][2*i+1] <= lvl_stamp[l][2*i])) begin
					lvl_en[l+1][i]    = 1'b1;
					lvl_stamp[l+1][i] = lvl_stamp[l][2*i+1];
					lvl_idx[l+1][i]   = lvl_idx[l][2*i+1];
				end else begin
					lvl_en[l+1][i]    = lvl_en[l][2*i];
					lvl_stamp[l+1][i] = lvl_stamp[l][2*i];
					lvl_idx[l+1][i]   = lvl_idx[l][2*i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			hit_q  <= hit_c;
			free_q <= free_c;
			if (hit_c) begin
				way_q <= hit_way_c;
			end else if (free_c) begin
				way_q <= free_way_c;
			end else begin
				way_q <= lvl_idx[WAY_W][0];
			end
		end
	end

	always_comb begin
		stamp_new = clock_q + 32'd1;
		if (hit_q) begin
			hit_add = mod_q ? 2'd2 : 2'd1;
		end else begin
			hit_add = mod_q ? 2'd1 : 2'd0;
		end
		hit_cnt_nx   = sat_add(hit_cnt_q, hit_add);
		miss_cnt_nx  = sat_add(miss_cnt_q, hit_q ? 2'd0 : 2'd1);
		evict_cnt_nx = sat_add(evict_cnt_q, (hit_q || free_q) ? 2'd0 : 2'd1);
		new_row = rd_row_q;
		new_row[way_q].valid = 1'b1;
		new_row[way_q].tag   = tag_q;
		new_row[way_q].stamp = stamp_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q     <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
		end else if (cmd.commit) begin
			clock_q     <= stamp_new;
			hit_cnt_q   <= hit_cnt_nx;
			miss_cnt_q  <= miss_cnt_nx;
			evict_cnt_q <= evict_cnt_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			priority if (hit_q) begin
				res_q.outcome <= OUT_HIT;
			end else if (free_q) begin
				res_q.outcome <= OUT_FILL;
			end else begin
				res_q.outcome <= OUT_EVICT;
			end
			res_q.way_used       <= 3'(way_q);
			res_q.hit_total      <= hit_cnt_nx;
			res_q.miss_total     <= miss_cnt_nx;
			res_q.eviction_total <= evict_cnt_nx;
		end
	end

	assign res_payload = res_q;

endmodule

// ===== rtl/sac_ctrl.sv =====
// Controller: clearing pass, request capture, lookup and commit sequencing.
module sac_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               res_valid,
	input  logic               res_ready,
	input  sac_pkg::sac_stat_t stat,
	output sac_pkg::sac_cmd_t  cmd
);
	import sac_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   res_valid_q;

	always_comb begin
		cmd.clear_step = (state_q == ST_CLEAR);
		cmd.capture    = (state_q == ST_IDLE) && req_valid;
		cmd.decide     = (state_q == ST_LOOKUP);
		cmd.commit     = (state_q == ST_COMMIT) && (!res_valid_q || res_ready);
	end

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (stat.clear_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

// ===== test/tb_set_assoc_cache_lru_tracker.sv =====
// Testbench for the set-associative cache LRU tracker, checked against a tag/valid/stamp predictor.
module tb_set_assoc_cache_lru_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	import sac_pkg::*;

	localparam logic [1:0] OPC_LOAD   = 2'd0;
	localparam logic [1:0] OPC_STORE  = 2'd1;
	localparam logic [1:0] OPC_UNUSED = 2'd3;
	localparam int LINES = (1 << SAC_MAX_SET_BITS) * SAC_MAX_WAYS;

	class lru_scoreboard;
		bit [3:0]  cfg_set_bits;
		bit [5:0]  cfg_offset_bits;
		bit [3:0]  cfg_ways = 4'd1;
		bit        line_valid [LINES];
		bit [63:0] line_tag [LINES];
		bit [31:0] line_stamp [LINES];
		bit [31:0] access_clock;
		bit [31:0] hit_count;
		bit [31:0] miss_count;
		bit [31:0] evict_count;
		sac_res_t  expected_results [$];
		int        fail_count;

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_SET_BITS:    cfg_set_bits = val[3:0];
				CFG_OFFSET_BITS: cfg_offset_bits = val[5:0];
				CFG_WAYS:        cfg_ways = val[3:0];
				default: ;
			endcase
		endfunction

		function bit [31:0] sat_add(bit [31:0] a, bit [31:0] b);
			bit [32:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[32] ? 32'hFFFF_FFFF : s[31:0];
		endfunction

		function void note_access(sac_req_t r);
			int        sb;
			int        ob;
			int        ways;
			int        base;
			int        way;
			int        w;
			bit        hit;
			bit        free_found;
			bit [63:0] addr;
			bit [63:0] tag;
			bit [31:0] oldest;
			sac_res_t  e;
			addr = r.access_address;
			sb = (cfg_set_bits > SAC_MAX_SET_BITS) ? SAC_MAX_SET_BITS : cfg_set_bits;
			ob = cfg_offset_bits;
			ways = (cfg_ways == 0) ? 1 : ((cfg_ways > SAC_MAX_WAYS) ? SAC_MAX_WAYS : cfg_ways);
			tag = (sb + ob >= 64) ? 64'd0 : (addr >> (sb + ob));
			base = int'((addr >> ob) & ((64'd1 << sb) - 64'd1)) * SAC_MAX_WAYS;
			access_clock = access_clock + 32'd1;
			hit = 1'b0;
			free_found = 1'b0;
			way = 0;
			for (w = 0; w < ways; w++) begin
				if (!hit && line_valid[base + w] && line_tag[base + w] == tag) begin
					hit = 1'b1;
					way = w;
				end
			end
			if (hit) begin
				line_stamp[base + way] = access_clock;
				hit_count = sat_add(hit_count, (r.opcode == OPC_MODIFY) ? 32'd2 : 32'd1);
				e.outcome = OUT_HIT;
			end else begin
				miss_count = sat_add(miss_count, 32'd1);
				if (r.opcode == OPC_MODIFY)
					hit_count = sat_add(hit_count, 32'd1);
				for (w = 0; w < ways; w++) begin
					if (!free_found && !line_valid[base + w]) begin
						free_found = 1'b1;
						way = w;
					end
				end
				if (free_found) begin
					e.outcome = OUT_FILL;
				end else begin
					oldest = line_stamp[base];
					way = 0;
					for (w = 0; w < ways; w++) begin
						if (line_stamp[base + w] <= oldest) begin
							oldest = line_stamp[base + w];
							way = w;
						end
					end
					evict_count = sat_add(evict_count, 32'd1);
					e.outcome = OUT_EVICT;
				end
				line_valid[base + way] = 1'b1;
				line_tag[base + way] = tag;
				line_stamp[base + way] = access_clock;
			end
			e.way_used = way[2:0];
			e.hit_total = hit_count;
			e.miss_total = miss_count;
			e.eviction_total = evict_count;
			expected_results.push_back(e);
		endfunction

		task report_mismatch(string msg);
			$display("ERROR at %0t: %s", $realtime, msg);
			fail_count++;
		endtask

		task check_result(sac_res_t got);
			sac_res_t want;
			if (expected_results.size() == 0) begin
				report_mismatch("result with no request outstanding");
				return;
			end
			want = expected_results.pop_front();
			if (got.outcome !== want.outcome)
				report_mismatch($sformatf("outcome %0d, want %0d", got.outcome, want.outcome));
			if (got.way_used !== want.way_used)
				report_mismatch($sformatf("way_used %0d, want %0d", got.way_used, want.way_used));
			if (got.hit_total !== want.hit_total)
				report_mismatch($sformatf("hit_total %0d, want %0d", got.hit_total,
					want.hit_total));
			if (got.miss_total !== want.miss_total)
				report_mismatch($sformatf("miss_total %0d, want %0d", got.miss_total,
					want.miss_total));
			if (got.eviction_total !== want.eviction_total)
				report_mismatch($sformatf("eviction_total %0d, want %0d", got.eviction_total,
					want.eviction_total));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	bit quiet;

	sac_stream_if #(.payload_t(sac_req_t)) req_if ();
	sac_stream_if #(.payload_t(sac_res_t)) res_if ();

	lru_scoreboard tracker = new();

	set_assoc_cache_lru_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_if),
		.res       (res_if)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		if (req_if.valid && req_if.ready)
			tracker.note_access(req_if.payload);
		if (res_if.valid && res_if.ready)
			tracker.check_result(res_if.payload);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [63:0] pick_address();
		int        sb;
		int        ob;
		int        r;
		bit [63:0] tag;
		bit [63:0] set_sel;
		bit [63:0] set_mask;
		sb = (tracker.cfg_set_bits > SAC_MAX_SET_BITS) ? SAC_MAX_SET_BITS : tracker.cfg_set_bits;
		ob = tracker.cfg_offset_bits;
		set_mask = (64'd1 << sb) - 64'd1;
		r = $urandom_range(0, 99);
		if (r < 15)
			return {$urandom, $urandom};
		tag = $urandom_range(0, tracker.cfg_ways + 2);
		if (r < 22)
			tag = {$urandom, $urandom};
		else if (r < 25)
			tag = ~64'd0;
		set_sel = (r < 35) ? {$urandom, $urandom} : $urandom_range(0, 3);
		return (tag << (sb + ob)) | ((set_sel & set_mask) << ob)
			| ({$urandom, $urandom} & ((64'd1 << ob) - 64'd1));
	endfunction

	task automatic send_access(logic [1:0] op, logic [63:0] addr);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			req_if.valid <= 1'b0;
		end
		@(negedge clk);
		req_if.valid <= 1'b1;
		req_if.payload <= '{opcode: op, access_address: addr};
		do @(posedge clk); while (!req_if.ready);
	endtask

	// hold off until every outstanding result is back
	task automatic wait_idle();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (tracker.expected_results.size() != 0)
			@(posedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.write_reg(idx, val);
	endtask

	task automatic set_geometry(int sb, int ob, int ways);
		wait_idle();
		write_reg(CFG_SET_BITS, CFG_DATA_W'(sb));
		write_reg(CFG_OFFSET_BITS, CFG_DATA_W'(ob));
		write_reg(CFG_WAYS, CFG_DATA_W'(ways));
	endtask

	initial begin
		res_if.ready = 1'b0;
		forever begin
			int gap;
			gap = pick_gap();
			if (gap != 0) begin
				@(negedge clk);
				res_if.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
		end
	end

	initial begin
		int geo [10][4];
		geo = '{
			'{3, 6, 8, 60}, '{0, 0, 1, 60}, '{10, 5, 8, 60}, '{15, 2, 15, 60},
			'{1, 63, 2, 60}, '{4, 60, 3, 60}, '{2, 0, 0, 60}, '{5, 12, 6, 60},
			'{0, 32, 8, 60}, '{1, 3, 4, 60}
		};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_if.valid = 1'b0;
		req_if.payload = '0;
		quiet = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// one way, one set: fill, hit, evict, and modify on hit and miss
		send_access(OPC_LOAD, 64'd0);
		send_access(OPC_STORE, 64'd0);
		send_access(OPC_LOAD, ~64'd0);
		send_access(OPC_MODIFY, ~64'd0);
		send_access(OPC_MODIFY, 64'd0);
		send_access(OPC_UNUSED, 64'd0);

		// clamped set bits and way count: fill all ways of one set, then evict LRU
		set_geometry(15, 0, 15);
		for (int t = 1; t <= 9; t++)
			send_access(OPC_STORE, (64'(t) << 10) | 64'd5);
		send_access(OPC_LOAD, (64'd1 << 10) | 64'd5);
		send_access(OPC_MODIFY, (64'd2 << 10) | 64'd5);

		// split wider than the address: tag reads as zero, set from bit 63
		set_geometry(10, 63, 0);
		send_access(OPC_LOAD, ~64'd0);
		send_access(OPC_LOAD, 64'h8000_0000_0000_0000);
		send_access(OPC_STORE, 64'd0);

		foreach (geo[p]) begin
			set_geometry(geo[p][0], geo[p][1], geo[p][2]);
			quiet = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < geo[p][3]; i++) begin
				if ($urandom_range(0, 99) == 0)
					wait_idle();
				send_access(2'($urandom_range(0, 3)), pick_address());
			end
		end

		wait_idle();
		repeat (20) @(negedge clk);
		if (tracker.fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
